// ----- rtl/sli_pkg.sv -----
// Package: shared widths, payload types and codes for the sorted list block.
package sli_pkg;

    localparam int CAPACITY = 16;
    localparam int VAL_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = $clog2(CAPACITY);

    typedef logic [1:0]       status_t;
    typedef logic [VAL_W-1:0] value_t;

    localparam logic    ACT_INSERT = 1'b0;
    localparam logic    ACT_DELETE = 1'b1;

    localparam status_t ST_DONE      = 2'd0;
    localparam status_t ST_NOT_FOUND = 2'd1;
    localparam status_t ST_FULL      = 2'd2;

    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_t;

endpackage

// ----- rtl/sli_req_if.sv -----
// Interface: request channel (action and value) with valid/ready handshake.
interface sli_req_if
    import sli_pkg::*;
();
    logic   valid;
    logic   ready;
    logic   action;
    value_t value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

// ----- rtl/sli_rsp_if.sv -----
// Interface: result channel (status, entry count, smallest) with valid/ready handshake.
interface sli_rsp_if
    import sli_pkg::*;
();
    logic       valid;
    logic       ready;
    status_t    status;
    logic [4:0] entry_count;
    value_t     smallest;

    modport source (output valid, output status, output entry_count, output smallest,
                    input ready);
    modport sink   (input valid, input status, input entry_count, input smallest,
                    output ready);
endinterface

// ----- rtl/sli_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ----- rtl/sli_cmp.sv -----
// Shared compare unit: less-than and equality of a stored entry against the request value.
module sli_cmp
    import sli_pkg::*;
(
    input  value_t entry,
    input  value_t value,
    output cmp_t   res
);
    assign res.lt = (entry < value);
    assign res.eq = (entry == value);
endmodule

// ----- rtl/sli_ram_wrap_note.sv -----
// Search and move sequencer: walks the entry store one address at a time.
module sli_seq
    import sli_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              action,
    input  value_t            value,
    input  logic              out_free,
    output logic              busy,
    output logic              finish,
    output status_t           status,
    output logic [CNT_W-1:0]  count,
    output value_t            smallest
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRD  = 3'd1;
    localparam logic [2:0] S_SCMP = 3'd2;
    localparam logic [2:0] S_MRD  = 3'd3;
    localparam logic [2:0] S_MWR  = 3'd4;
    localparam logic [2:0] S_PUT  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);

    logic [2:0]       state_reg, state_next;
    logic             act_reg, act_next;
    value_t           val_reg, val_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    status_t          st_reg, st_next;
    value_t           small_reg, small_next;

    logic             ram_we, ram_re;
    logic [CNT_W-1:0] wr_idx, rd_idx;
    value_t           ram_wdata, ram_rdata;
    cmp_t             cmp;
    logic [CNT_W-1:0] idx_inc, idx_dec;

    sli_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_idx[ADDR_W-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_idx[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    sli_cmp u_cmp (
        .entry (ram_rdata),
        .value (val_reg),
        .res   (cmp)
    );

    assign idx_inc = idx_reg + ONE;
    assign idx_dec = idx_reg - ONE;

    always_comb
    begin
        state_next = state_reg;
        act_next   = act_reg;
        val_next   = val_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        st_next    = st_reg;
        small_next = small_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        wr_idx     = idx_reg;
        rd_idx     = idx_reg;
        ram_wdata  = ram_rdata;
        finish     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    act_next = action;
                    val_next = value;
                    st_next  = ST_DONE;
                    idx_next = '0;
                    pos_next = '0;
                    if (action == ACT_INSERT && cnt_reg == FULL_CNT)
                    begin
                        st_next    = ST_FULL;
                        state_next = S_DONE;
                    end
                    else if (cnt_reg == '0)
                    begin
                        if (action == ACT_INSERT)
                        begin
                            state_next = S_PUT;
                        end
                        else
                        begin
                            st_next    = ST_NOT_FOUND;
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        state_next = S_SRD;
                    end
                end
            end
            S_SRD:
            begin
                ram_re     = 1'b1;
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                if (act_reg == ACT_INSERT)
                begin
                    if (!cmp.lt)
                    begin
                        // entry >= value: open a gap here, move tail up from the end
                        pos_next   = idx_reg;
                        idx_next   = cnt_reg;
                        state_next = S_MRD;
                    end
                    else if (idx_inc == cnt_reg)
                    begin
                        pos_next   = cnt_reg;
                        state_next = S_PUT;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = S_SRD;
                    end
                end
                else
                begin
                    if (cmp.eq)
                    begin
                        pos_next = idx_reg;
                        if (idx_inc == cnt_reg)
                        begin
                            cnt_next   = cnt_reg - ONE;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_MRD;
                        end
                    end
                    else if (idx_inc == cnt_reg)
                    begin
                        st_next    = ST_NOT_FOUND;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = S_SRD;
                    end
                end
            end
            S_MRD:
            begin
                ram_re     = 1'b1;
                rd_idx     = (act_reg == ACT_INSERT) ? idx_dec : idx_inc;
                state_next = S_MWR;
            end
            S_MWR:
            begin
                ram_we = 1'b1;
                if (idx_reg == '0)
                begin
                    small_next = ram_rdata;
                end
                if (act_reg == ACT_INSERT)
                begin
                    idx_next   = idx_dec;
                    state_next = (idx_dec == pos_reg) ? S_PUT : S_MRD;
                end
                else
                begin
                    idx_next = idx_inc;
                    if (idx_inc == cnt_reg - ONE)
                    begin
                        cnt_next   = cnt_reg - ONE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MRD;
                    end
                end
            end
            S_PUT:
            begin
                ram_we    = 1'b1;
                wr_idx    = pos_reg;
                ram_wdata = val_reg;
                if (pos_reg == '0)
                begin
                    small_next = val_reg;
                end
                cnt_next   = cnt_reg + ONE;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        val_reg   <= val_next;
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        st_reg    <= st_next;
        small_reg <= small_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign status   = st_reg;
    assign count    = cnt_reg;
    assign smallest = (cnt_reg == '0) ? '0 : small_reg;
endmodule

// ----- rtl/sorted_list_insert_delete.sv -----
// Top level: sorted value store with insert and delete requests and one result per request.
//
//  channel | dir | fields                          | transfer when
//  --------+-----+---------------------------------+------------------------
//  req     | in  | action, value                   | req.valid && req.ready
//  rsp     | out | status, entry_count, smallest   | rsp.valid && rsp.ready
//
// Flow: one request at a time. The search reads one entry at a time
// through the single store read port and the shared compare unit; each entry moved
// to open or close a gap is read, then written. An insert then writes its value, and the
// sequencer returns to idle before the next request is taken.
// Reset: rst_n clears the sequencer and the entry count; store contents need no clearing.
// Stalls: a finished result waits in the output register; a new request is taken while it
// waits, and the next result is held back until the waiting one has been transferred.
module sorted_list_insert_delete
    import sli_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    sli_req_if.sink    req,
    sli_rsp_if.source  rsp
);
    logic             busy;
    logic             finish;
    logic             out_free;
    status_t          seq_status;
    logic [CNT_W-1:0] seq_count;
    value_t           seq_smallest;
    logic [CNT_W+4:0] cnt_ext;

    logic             rsp_valid_reg, rsp_valid_next;
    status_t          rsp_status_reg;
    logic [4:0]       rsp_count_reg;
    value_t           rsp_small_reg;

    // take a request only while the sequencer is idle
    assign req.ready = !busy;

    // the output register is free when empty or being drained this cycle
    assign out_free = !rsp_valid_reg || rsp.ready;

    sli_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (req.valid && !busy),
        .action   (req.action),
        .value    (req.value),
        .out_free (out_free),
        .busy     (busy),
        .finish   (finish),
        .status   (seq_status),
        .count    (seq_count),
        .smallest (seq_smallest)
    );

    // count is reported modulo 32
    assign cnt_ext = {5'b0, seq_count};

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (finish)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // load the result payload as the sequencer finishes
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            rsp_status_reg <= seq_status;
            rsp_count_reg  <= cnt_ext[4:0];
            rsp_small_reg  <= seq_smallest;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.entry_count = rsp_count_reg;
    assign rsp.smallest    = rsp_small_reg;
endmodule
